>>> design/dmab_pkg.sv
// ----------------------------------------------------------------------------
// dmab_pkg
// Shared constants, codes and the colour level table for the word DMA
// sequencer with nibble blit.
// ----------------------------------------------------------------------------
package dmab_pkg;

    // address and field widths
    localparam int ADDR_W    = 22;
    localparam int WORD_W    = 16;
    localparam int CNT_REG_W = 8;
    localparam int TGT_W     = 3;
    localparam int DEV_W     = 3;
    localparam int IDX_W     = 8;
    localparam int RGB_W     = 24;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    // parameter defaults
    localparam int DEF_MAX_WORDS  = 256;
    localparam int DEF_MAX_BURSTS = 256;

    // register indexes
    localparam logic [2:0] REG_SRC_START  = 3'd0;
    localparam logic [2:0] REG_DST_START  = 3'd1;
    localparam logic [2:0] REG_WORDS      = 3'd2;
    localparam logic [2:0] REG_BURSTS     = 3'd3;
    localparam logic [2:0] REG_ALIGN      = 3'd4;
    localparam logic [2:0] REG_BLOCK_512  = 3'd5;
    localparam logic [2:0] REG_DEV_SEL    = 3'd6;
    localparam logic [2:0] REG_DIRECTION  = 3'd7;

    // input modes
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_BEAT  = 1'b1;

    // device select codes
    localparam logic [DEV_W-1:0] DEV_RAM     = 3'd0;
    localparam logic [DEV_W-1:0] DEV_SPI     = 3'd1;
    localparam logic [DEV_W-1:0] DEV_IDE     = 3'd2;
    localparam logic [DEV_W-1:0] DEV_PALETTE = 3'd3;
    localparam logic [DEV_W-1:0] DEV_SPRITE  = 3'd4;

    // write target codes
    localparam logic [TGT_W-1:0] TGT_NONE    = 3'd0;
    localparam logic [TGT_W-1:0] TGT_RAM     = 3'd1;
    localparam logic [TGT_W-1:0] TGT_SPI     = 3'd2;
    localparam logic [TGT_W-1:0] TGT_IDE     = 3'd3;
    localparam logic [TGT_W-1:0] TGT_PALETTE = 3'd4;
    localparam logic [TGT_W-1:0] TGT_SPRITE  = 3'd5;

    // block sizes in bytes
    localparam logic [ADDR_W-1:0] BLK_256 = ADDR_W'(256);
    localparam logic [ADDR_W-1:0] BLK_512 = ADDR_W'(512);
    localparam logic [ADDR_W-1:0] LOW_256 = ADDR_W'('hFF);
    localparam logic [ADDR_W-1:0] LOW_512 = ADDR_W'('h1FF);
    localparam logic [ADDR_W-1:0] PTR_STEP = ADDR_W'(2);

    // 5-bit channel to 8-bit level, codes above 24 clamp to full scale
    function automatic logic [7:0] f_level(input logic [4:0] c);
        logic [7:0] v;
        case (c)
            5'd0:    v = 8'd0;
            5'd1:    v = 8'd10;
            5'd2:    v = 8'd21;
            5'd3:    v = 8'd31;
            5'd4:    v = 8'd42;
            5'd5:    v = 8'd53;
            5'd6:    v = 8'd63;
            5'd7:    v = 8'd74;
            5'd8:    v = 8'd85;
            5'd9:    v = 8'd95;
            5'd10:   v = 8'd106;
            5'd11:   v = 8'd117;
            5'd12:   v = 8'd127;
            5'd13:   v = 8'd138;
            5'd14:   v = 8'd149;
            5'd15:   v = 8'd159;
            5'd16:   v = 8'd170;
            5'd17:   v = 8'd181;
            5'd18:   v = 8'd191;
            5'd19:   v = 8'd202;
            5'd20:   v = 8'd213;
            5'd21:   v = 8'd223;
            5'd22:   v = 8'd234;
            5'd23:   v = 8'd245;
            default: v = 8'd255;
        endcase
        return v;
    endfunction

endpackage

>>> design/dma_burst_engine_with_blit_top.sv
// An accepted word is held in the input register; its result is loaded into the
// result register once that register is empty or being read out. Throughput:
// one word per cycle while the result channel does not stall; the pointer and
// counter update in that pass is the only recurrence. Reset is synchronous,
// active low, and clears the configuration, pointers, counters and running flag.
// ----------------------------------------------------------------------------
// dma_burst_engine_with_blit_top
// Word DMA sequencer: bursts of 16-bit beats with aligned block wrap,
// nibble blit merge, device routing and palette colour conversion.
// ----------------------------------------------------------------------------
module dma_burst_engine_with_blit_top #(
    parameter int MAX_WORDS  = dmab_pkg::DEF_MAX_WORDS,
    parameter int MAX_BURSTS = dmab_pkg::DEF_MAX_BURSTS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dmab_pkg::PADDR_W-1:0]     paddr,
    input  logic [dmab_pkg::PDATA_W-1:0]     pwdata,
    output logic [dmab_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_mode,
    input  logic [dmab_pkg::WORD_W-1:0]      i_source_word,
    input  logic [dmab_pkg::WORD_W-1:0]      i_dest_old_word,
    input  logic [dmab_pkg::WORD_W-1:0]      i_device_word,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [dmab_pkg::TGT_W-1:0]       o_write_target,
    output logic [dmab_pkg::ADDR_W-1:0]      o_write_address,
    output logic [dmab_pkg::IDX_W-1:0]       o_table_index,
    output logic [dmab_pkg::WORD_W-1:0]      o_write_word,
    output logic [dmab_pkg::RGB_W-1:0]       o_colour_rgb,
    output logic [dmab_pkg::ADDR_W-1:0]      o_next_source,
    output logic [dmab_pkg::ADDR_W-1:0]      o_next_dest,
    output logic                             o_last
);
    import dmab_pkg::*;

    // counter widths follow the parameter bounds, never wider than the count regs
    localparam int WCNT_W = (MAX_WORDS >= 256) ? CNT_REG_W :
                            ((MAX_WORDS <= 2) ? 1 : $clog2(MAX_WORDS));
    localparam int BCNT_W = (MAX_BURSTS >= 256) ? CNT_REG_W :
                            ((MAX_BURSTS <= 2) ? 1 : $clog2(MAX_BURSTS));
    localparam logic [CNT_REG_W-1:0] WMAX_LIM =
        CNT_REG_W'((MAX_WORDS - 1 > 255) ? 255 : MAX_WORDS - 1);
    localparam logic [CNT_REG_W-1:0] BMAX_LIM =
        CNT_REG_W'((MAX_BURSTS - 1 > 255) ? 255 : MAX_BURSTS - 1);

    // configuration registers
    logic [ADDR_W-1:0]    r_src_start;
    logic [ADDR_W-1:0]    r_dst_start;
    logic [CNT_REG_W-1:0] r_words;
    logic [CNT_REG_W-1:0] r_bursts;
    logic [1:0]           r_align;
    logic                 r_block_512;
    logic [DEV_W-1:0]     r_dev_sel;
    logic                 r_direction;

    logic       w_cfg_wr;
    logic [2:0] w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[4:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_start <= '0;
            r_dst_start <= '0;
            r_words     <= '0;
            r_bursts    <= '0;
            r_align     <= '0;
            r_block_512 <= 1'b0;
            r_dev_sel   <= '0;
            r_direction <= 1'b0;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                REG_SRC_START: r_src_start <= pwdata[ADDR_W-1:0];
                REG_DST_START: r_dst_start <= pwdata[ADDR_W-1:0];
                REG_WORDS:     r_words     <= pwdata[CNT_REG_W-1:0];
                REG_BURSTS:    r_bursts    <= pwdata[CNT_REG_W-1:0];
                REG_ALIGN:     r_align     <= pwdata[1:0];
                REG_BLOCK_512: r_block_512 <= pwdata[0];
                REG_DEV_SEL:   r_dev_sel   <= pwdata[DEV_W-1:0];
                REG_DIRECTION: r_direction <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (w_cfg_idx)
            REG_SRC_START: prdata = PDATA_W'(r_src_start);
            REG_DST_START: prdata = PDATA_W'(r_dst_start);
            REG_WORDS:     prdata = PDATA_W'(r_words);
            REG_BURSTS:    prdata = PDATA_W'(r_bursts);
            REG_ALIGN:     prdata = PDATA_W'(r_align);
            REG_BLOCK_512: prdata = PDATA_W'(r_block_512);
            REG_DEV_SEL:   prdata = PDATA_W'(r_dev_sel);
            REG_DIRECTION: prdata = PDATA_W'(r_direction);
            default:       prdata = '0;
        endcase
    end

    // input register
    logic              r_in_vld;
    logic              r_in_mode;
    logic [WORD_W-1:0] r_in_src;
    logic [WORD_W-1:0] r_in_dst;
    logic [WORD_W-1:0] r_in_dev;
    logic              r_out_vld;
    logic              w_fire;

    assign w_fire     = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_mode <= i_mode;
            r_in_src  <= i_source_word;
            r_in_dst  <= i_dest_old_word;
            r_in_dev  <= i_device_word;
        end
    end

    // transfer state
    logic [ADDR_W-1:0] r_src_ptr, n_src_ptr;
    logic [ADDR_W-1:0] r_dst_ptr, n_dst_ptr;
    logic [ADDR_W-1:0] r_src_base, n_src_base;
    logic [ADDR_W-1:0] r_dst_base, n_dst_base;
    logic [WCNT_W-1:0] r_beat_cnt, n_beat_cnt;
    logic [BCNT_W-1:0] r_burst_cnt, n_burst_cnt;
    logic              r_running, n_running;

    // result fields
    logic [TGT_W-1:0]  n_target;
    logic [ADDR_W-1:0] n_waddr;
    logic [IDX_W-1:0]  n_tidx;
    logic [WORD_W-1:0] n_wdata;
    logic [RGB_W-1:0]  n_rgb;
    logic              n_last;

    // pointer stepping and burst limits
    logic [ADDR_W-1:0]    w_low, w_blk, w_src_inc, w_dst_inc, w_src_step, w_dst_step;
    logic [CNT_REG_W-1:0] w_wmax, w_bmax;
    logic                 w_sal, w_dal, w_burst_end, w_xfer_end;
    logic [WORD_W-1:0]    w_blit;

    assign w_sal     = r_align[0];
    assign w_dal     = r_align[1];
    assign w_low     = r_block_512 ? LOW_512 : LOW_256;
    assign w_blk     = r_block_512 ? BLK_512 : BLK_256;
    assign w_src_inc = r_src_ptr + PTR_STEP;
    assign w_dst_inc = r_dst_ptr + PTR_STEP;
    assign w_src_step = w_sal ? ((r_src_ptr & ~w_low) | (w_src_inc & w_low)) : w_src_inc;
    assign w_dst_step = w_dal ? ((r_dst_ptr & ~w_low) | (w_dst_inc & w_low)) : w_dst_inc;
    assign w_wmax      = (r_words > WMAX_LIM) ? WMAX_LIM : r_words;
    assign w_bmax      = (r_bursts > BMAX_LIM) ? BMAX_LIM : r_bursts;
    assign w_burst_end = CNT_REG_W'(r_beat_cnt) >= w_wmax;
    assign w_xfer_end  = CNT_REG_W'(r_burst_cnt) >= w_bmax;

    // blit keeps every nonzero source nibble
    always_comb begin
        for (int k = 0; k < WORD_W / 4; k++) begin
            w_blit[4*k +: 4] = (r_in_src[4*k +: 4] != 4'd0) ? r_in_src[4*k +: 4]
                                                            : r_in_dst[4*k +: 4];
        end
    end

    // one pass: write action and next pointers
    always_comb begin
        n_src_ptr   = r_src_ptr;
        n_dst_ptr   = r_dst_ptr;
        n_src_base  = r_src_base;
        n_dst_base  = r_dst_base;
        n_beat_cnt  = r_beat_cnt;
        n_burst_cnt = r_burst_cnt;
        n_running   = r_running;
        n_target    = TGT_NONE;
        n_waddr     = '0;
        n_tidx      = '0;
        n_wdata     = '0;
        n_rgb       = '0;
        n_last      = 1'b0;

        if (r_in_mode == MODE_START) begin
            n_src_base  = r_src_start;
            n_dst_base  = r_dst_start;
            n_src_ptr   = r_src_start;
            n_dst_ptr   = r_dst_start;
            n_beat_cnt  = '0;
            n_burst_cnt = '0;
            n_running   = 1'b1;
        end else if (r_running) begin
            // route the word by device
            case (r_dev_sel)
                DEV_RAM: begin
                    n_target = TGT_RAM;
                    n_waddr  = r_dst_ptr;
                    n_wdata  = r_direction ? w_blit : r_in_src;
                end
                DEV_SPI, DEV_IDE: begin
                    if (r_direction) begin
                        n_target = (r_dev_sel == DEV_SPI) ? TGT_SPI : TGT_IDE;
                        n_wdata  = r_in_src;
                    end else begin
                        n_target = TGT_RAM;
                        n_waddr  = r_dst_ptr;
                        n_wdata  = r_in_dev;
                    end
                end
                DEV_PALETTE: begin
                    n_target = TGT_PALETTE;
                    n_tidx   = r_dst_ptr[IDX_W:1];
                    n_wdata  = r_in_src;
                    n_rgb    = {f_level(r_in_src[14:10]), f_level(r_in_src[9:5]),
                                f_level(r_in_src[4:0])};
                end
                DEV_SPRITE: begin
                    n_target = TGT_SPRITE;
                    n_tidx   = r_dst_ptr[IDX_W:1];
                    n_wdata  = r_in_src;
                end
                default: ;
            endcase

            // advance pointers and counters
            if (w_burst_end) begin
                n_src_base = w_sal ? (r_src_base + w_blk) : w_src_step;
                n_dst_base = w_dal ? (r_dst_base + w_blk) : w_dst_step;
                n_src_ptr  = n_src_base;
                n_dst_ptr  = n_dst_base;
                n_beat_cnt = '0;
                if (w_xfer_end) begin
                    n_last      = 1'b1;
                    n_running   = 1'b0;
                    n_burst_cnt = '0;
                end else begin
                    n_burst_cnt = r_burst_cnt + BCNT_W'(1);
                end
            end else begin
                n_src_ptr  = w_src_step;
                n_dst_ptr  = w_dst_step;
                n_beat_cnt = r_beat_cnt + WCNT_W'(1);
            end
        end
    end

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_ptr   <= '0;
            r_dst_ptr   <= '0;
            r_src_base  <= '0;
            r_dst_base  <= '0;
            r_beat_cnt  <= '0;
            r_burst_cnt <= '0;
            r_running   <= 1'b0;
        end else if (w_fire) begin
            r_src_ptr   <= n_src_ptr;
            r_dst_ptr   <= n_dst_ptr;
            r_src_base  <= n_src_base;
            r_dst_base  <= n_dst_base;
            r_beat_cnt  <= n_beat_cnt;
            r_burst_cnt <= n_burst_cnt;
            r_running   <= n_running;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fire) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            o_write_target  <= n_target;
            o_write_address <= n_waddr;
            o_table_index   <= n_tidx;
            o_write_word    <= n_wdata;
            o_colour_rgb    <= n_rgb;
            o_next_source   <= n_src_ptr;
            o_next_dest     <= n_dst_ptr;
            o_last          <= n_last;
        end
    end

    assign o_out_valid = r_out_vld;

    // the final beat of a transfer leaves the sequencer idle
    a_last_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && n_last) |=> !r_running)
        else $error("running still set after final beat");

    // a beat while idle writes nothing
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_mode == MODE_BEAT && !r_running) |=> (o_write_target == TGT_NONE))
        else $error("write issued while idle");

    // write address only carries a value for ram writes
    a_addr_ram_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_write_target != TGT_RAM) |-> (o_write_address == '0))
        else $error("write address set for non-ram target");

    // beat counter never runs past the largest burst length the parameter allows
    a_beat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_REG_W'(r_beat_cnt) <= WMAX_LIM)
        else $error("beat counter out of range");

endmodule
